// File: hw/rtl/assert_macros.svh
// Assertion macros used by the region decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/bard_pkg.sv
// Package of the bus address region decoder: widths, opcodes and chain types.
package bard_pkg;

  localparam int AddrW             = 32;
  localparam int DevW              = 8;
  localparam int MaxRegionsDefault = 8;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Item travelling down the cell chain, with its partial result.
  typedef struct packed {
    logic             opcode;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic [AddrW:0]   new_end;
    logic [AddrW:0]   last;
    logic [DevW-1:0]  dev;
    logic             pow2;
    logic             overlap;
    logic             hit;
    logic [DevW-1:0]  res_dev;
    logic [AddrW-1:0] res_offset;
  } token_t;

  // Region write, broadcast to all cells at commit.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] mask;
    logic [AddrW:0]   last;
    logic [DevW-1:0]  dev;
  } region_wr_t;

endpackage

// File: hw/rtl/bard_cell.sv
// One cell of the region chain: holds one region and checks the passing item.
module bard_cell #(
  parameter int Index = 0,
  parameter int CntW  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [CntW-1:0]     count_i,
  input  bard_pkg::region_wr_t wr_i,
  input  logic                valid_i,
  input  bard_pkg::token_t    tok_i,
  output logic                valid_o,
  output bard_pkg::token_t    tok_o
);

  logic [bard_pkg::AddrW-1:0] base_q;
  logic [bard_pkg::AddrW-1:0] mask_q;
  logic [bard_pkg::AddrW:0]   last_q;
  logic [bard_pkg::DevW-1:0]  dev_q;

  logic             valid_q;
  bard_pkg::token_t tok_q, tok_d;
  logic             active;
  logic [bard_pkg::AddrW:0] base_x, addr_x;

  // Only regions below the fill level take part.
  assign active = CntW'(Index) < count_i;
  assign base_x = {1'b0, base_q};
  assign addr_x = {1'b0, tok_i.addr};

  always_ff @(posedge clk_i) begin
    if (wr_i.we && count_i == CntW'(Index)) begin
      base_q <= wr_i.base;
      mask_q <= wr_i.mask;
      last_q <= wr_i.last;
      dev_q  <= wr_i.dev;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (valid_i && active) begin
      if (tok_i.opcode == bard_pkg::OP_ADD) begin
        if ((base_x >= addr_x && base_x < tok_i.new_end) ||
            (addr_x >= base_x && addr_x <= last_q)) begin
          tok_d.overlap = 1'b1;
        end
      end else if (!tok_i.hit && (tok_i.addr & mask_q) == base_q) begin
        // first match wins; later cells see hit already set
        tok_d.hit        = 1'b1;
        tok_d.res_dev    = dev_q;
        tok_d.res_offset = tok_i.addr & ~mask_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

// File: hw/rtl/bus_address_region_decoder.sv
// Top level of the bus address region decoder: entry, cell chain, commit and output.
//
// Input channel (in_valid_i/in_ready_o) carries one item per transfer: opcode_i
// selects add (store a region of region_size_i bytes at address_i for device_id_i)
// or decode (look up address_i). Output channel (out_valid_o/out_ready_i) returns
// exactly one result per item.
// An item walks a row of MAX_REGIONS cells, one cell per cycle; each cell holds
// one region and checks overlap (add) or match (decode) against it. As the item
// leaves the last cell, its result is loaded into the output register. One item
// is in flight at a time: in_ready_o rises again once the result sits in the
// output register, so the block takes no new item until the last one is through.
// An accepted add is written into the next free cell as its result is loaded,
// so the following item already sees it.
// Reset empties the table (fill count zero) and drops any item in flight.
// When the receiver stalls, a finished result waits in the output register; the
// next item is still taken and holds at the chain end until the register frees.
`include "assert_macros.svh"

module bus_address_region_decoder #(
  parameter int MAX_REGIONS = bard_pkg::MaxRegionsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       opcode_i,
  input  logic [bard_pkg::AddrW-1:0] address_i,
  input  logic [bard_pkg::AddrW-1:0] region_size_i,
  input  logic [bard_pkg::DevW-1:0]  device_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       add_accepted_o,
  output logic                       hit_o,
  output logic [bard_pkg::DevW-1:0]  device_out_o,
  output logic [bard_pkg::AddrW-1:0] offset_o
);

  localparam int CntW = $clog2(MAX_REGIONS + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic            res_acc_q, res_hit_q;
  logic [bard_pkg::DevW-1:0]  res_dev_q;
  logic [bard_pkg::AddrW-1:0] res_off_q;

  bard_pkg::token_t     tok_chain [MAX_REGIONS+1];
  logic [MAX_REGIONS:0] valid_chain;
  bard_pkg::region_wr_t wr;
  bard_pkg::token_t     exit_tok;
  logic                 exit_valid;
  logic                 adv;
  logic                 in_xfer;
  logic                 room;
  logic                 add_ok;
  logic [bard_pkg::AddrW-1:0] size_m1;

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Entry: size checks and range ends, taken at 33 bits.
  assign size_m1 = region_size_i - bard_pkg::AddrW'(1);
  always_comb begin
    tok_chain[0].opcode     = opcode_i;
    tok_chain[0].addr       = address_i;
    tok_chain[0].mask       = ~size_m1;
    tok_chain[0].new_end    = {1'b0, address_i} + {1'b0, region_size_i};
    tok_chain[0].last       = {1'b0, address_i} + {1'b0, size_m1};
    tok_chain[0].dev        = device_id_i;
    tok_chain[0].pow2       = (region_size_i != '0) && ((region_size_i & size_m1) == '0);
    tok_chain[0].overlap    = 1'b0;
    tok_chain[0].hit        = 1'b0;
    tok_chain[0].res_dev    = '0;
    tok_chain[0].res_offset = '0;
  end
  assign valid_chain[0] = in_xfer;

  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
    bard_cell #(
      .Index (k),
      .CntW  (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .count_i (count_q),
      .wr_i    (wr),
      .valid_i (valid_chain[k]),
      .tok_i   (tok_chain[k]),
      .valid_o (valid_chain[k+1]),
      .tok_o   (tok_chain[k+1])
    );
  end

  assign exit_tok   = tok_chain[MAX_REGIONS];
  assign exit_valid = valid_chain[MAX_REGIONS];

  // Chain holds only while a finished item waits on a full output register.
  assign adv = !(exit_valid && out_valid_q && !out_ready_i);

  assign room   = count_q < CntW'(MAX_REGIONS);
  assign add_ok = (exit_tok.opcode == bard_pkg::OP_ADD) && exit_tok.pow2 &&
                  !exit_tok.overlap && room;

  always_comb begin
    wr.we   = exit_valid && adv && add_ok;
    wr.base = exit_tok.addr;
    wr.mask = exit_tok.mask;
    wr.last = exit_tok.last;
    wr.dev  = exit_tok.dev;
  end

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (wr.we) begin
      count_d = count_q + CntW'(1);
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end else if (exit_valid && adv) begin
      busy_d = 1'b0;
    end
    if (exit_valid && adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_valid && adv) begin
      res_acc_q <= add_ok;
      res_hit_q <= exit_tok.hit;
      res_dev_q <= exit_tok.res_dev;
      res_off_q <= exit_tok.res_offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign add_accepted_o = res_acc_q;
  assign hit_o          = res_hit_q;
  assign device_out_o   = res_dev_q;
  assign offset_o       = res_off_q;

  `ASSERT_CLK(a_count_bound, count_q <= CntW'(MAX_REGIONS), "region count above table depth")
  `ASSERT_CLK(a_one_in_flight, $onehot0(valid_chain[MAX_REGIONS:1]), "more than one item in chain")
  `ASSERT_CLK(a_busy_tracks_chain, (valid_chain[MAX_REGIONS:1] != '0) |-> busy_q, "item in chain while idle")
  `ASSERT_NEVER(a_add_and_hit, out_valid_q && res_acc_q && res_hit_q, "result both add and hit")
  `ASSERT_CLK(a_count_on_commit, (count_q != $past(count_q)) |-> $past(wr.we), "count moved without commit")

endmodule
